// File: hdl/resistive_touch_scan_sequencer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the touch scan sequencer
// Concurrent property shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef RESISTIVE_TOUCH_SCAN_SEQUENCER_ASSERT_SVH
`define RESISTIVE_TOUCH_SCAN_SEQUENCER_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define RTSS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define RTSS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/rtss_pkg.sv
// ----------------------------------------------------------------------------
// rtss_pkg
// Types, constants and word packing for the touch scan sequencer.
// ----------------------------------------------------------------------------
package rtss_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int COUNT_BITS  = 16;
    localparam int SETTLE_BITS = 16;
    localparam int COORD_BITS  = 8;
    localparam int MASK_BITS   = 4;
    localparam int PHASE_BITS  = 3;

    localparam logic [SETTLE_BITS-1:0] SETTLE_RESET = 16'd5;
    localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = {COUNT_BITS{1'b1}};

    // Pin bits: left, right, top, bottom
    localparam logic [MASK_BITS-1:0] PIN_LEFT   = 4'h1;
    localparam logic [MASK_BITS-1:0] PIN_RIGHT  = 4'h2;
    localparam logic [MASK_BITS-1:0] PIN_TOP    = 4'h4;
    localparam logic [MASK_BITS-1:0] PIN_BOTTOM = 4'h8;
    localparam logic [MASK_BITS-1:0] PIN_ALL    = 4'hF;
    localparam logic [MASK_BITS-1:0] PIN_NONE   = 4'h0;

    localparam int S_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    // Result word layout, lowest bit first
    localparam int OUT_EN_LSB    = 0;
    localparam int OUT_LVL_LSB   = OUT_EN_LSB + MASK_BITS;
    localparam int OUT_START_BIT = OUT_LVL_LSB + MASK_BITS;
    localparam int OUT_CHAN_BIT  = OUT_START_BIT + 1;
    localparam int OUT_X_LSB     = OUT_CHAN_BIT + 1;
    localparam int OUT_Y_LSB     = OUT_X_LSB + COORD_BITS;
    localparam int OUT_READY_BIT = OUT_Y_LSB + COORD_BITS;
    localparam int OUT_PHASE_LSB = OUT_READY_BIT + 1;
    localparam int OUT_FIELD_W   = OUT_PHASE_LSB + PHASE_BITS;
    localparam int M_TDATA_W     = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef enum logic [PHASE_BITS-1:0] {
        PH_DISCHARGE = 3'd0,
        PH_SETTLE_X  = 3'd1,
        PH_READ_X    = 3'd2,
        PH_SETTLE_Y  = 3'd3,
        PH_READ_Y    = 3'd4,
        PH_READY     = 3'd5
    } phase_t;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_DONE = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t                   cmd;
        logic [SAMPLE_BITS-1:0] sample;
    } item_t;

    typedef struct packed {
        logic [MASK_BITS-1:0]  drive_enable;
        logic [MASK_BITS-1:0]  drive_level;
        logic                  adc_start;
        logic                  adc_channel;
        logic [COORD_BITS-1:0] x_position;
        logic [COORD_BITS-1:0] y_position;
        logic                  pair_ready;
        phase_t                phase;
    } result_t;

    function automatic logic [M_TDATA_W-1:0] pack_result(input result_t r);
        logic [OUT_FIELD_W-1:0] fields;
        fields = {r.phase, r.pair_ready, r.y_position, r.x_position,
                  r.adc_channel, r.adc_start, r.drive_level, r.drive_enable};
        return M_TDATA_W'(fields);
    endfunction

endpackage

// File: hdl/rtss_in_reg.sv
// ----------------------------------------------------------------------------
// rtss_in_reg
// Input register stage: holds one accepted word for the scan core.
// ----------------------------------------------------------------------------
module rtss_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  rtss_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output rtss_pkg::item_t out_item
);
    import rtss_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Take a new word when the register is empty or the held one leaves in the same cycle.
    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// File: hdl/rtss_scan_core.sv
// ----------------------------------------------------------------------------
// rtss_scan_core
// Scan phase machine, settle counter, captured coordinates and result register.
// ----------------------------------------------------------------------------
module rtss_scan_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [rtss_pkg::SETTLE_BITS-1:0]  settle_ticks,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  rtss_pkg::item_t                   in_item,
    output logic                              res_valid,
    input  logic                              res_ready,
    output rtss_pkg::result_t                 res
);
    import rtss_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  conv_reg, conv_next;
    logic [COORD_BITS-1:0] x_reg, x_next;
    logic [COORD_BITS-1:0] y_reg, y_next;
    logic [MASK_BITS-1:0]  en_reg, en_next;
    logic [MASK_BITS-1:0]  lvl_reg, lvl_next;
    logic                  res_valid_reg, res_valid_next;
    result_t               res_reg, res_next;

    logic                  fire;
    logic                  is_tick;
    logic                  is_done;
    logic [COUNT_BITS-1:0] count_inc;
    logic                  settle_hit;
    logic [COORD_BITS-1:0] coord;
    logic                  start;
    logic                  ready;

    assign in_ready = !res_valid_reg || res_ready;
    assign fire     = in_valid && in_ready;
    assign is_tick  = (in_item.cmd == CMD_TICK) && !conv_reg;
    assign is_done  = (in_item.cmd == CMD_DONE) && conv_reg;
    assign coord    = in_item.sample[SAMPLE_BITS-1 -: COORD_BITS];

    // Saturating settle count; a saturated count ends the wait.
    assign count_inc  = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    assign settle_hit = (32'(count_inc) >= 32'(settle_ticks)) || (count_inc == COUNT_MAX);

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        if (is_done) begin
            phase_next = (phase_reg == PH_READ_X) ? PH_SETTLE_Y : PH_READY;
        end else if (is_tick) begin
            unique case (phase_reg) inside
                PH_DISCHARGE: phase_next = PH_SETTLE_X;
                PH_SETTLE_X: begin
                    if (settle_hit) phase_next = PH_READ_X;
                end
                PH_SETTLE_Y: begin
                    if (settle_hit) phase_next = PH_READ_Y;
                end
                PH_READ_X, PH_READ_Y: phase_next = phase_reg;
                default: phase_next = PH_DISCHARGE;
            endcase
        end
    end

    // Datapath and pulses
    always_comb begin
        count_next = count_reg;
        conv_next  = conv_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        en_next    = en_reg;
        lvl_next   = lvl_reg;
        start      = 1'b0;
        ready      = 1'b0;
        if (is_done) begin
            conv_next  = 1'b0;
            count_next = '0;
            en_next    = PIN_ALL;
            lvl_next   = PIN_NONE;
            if (phase_reg == PH_READ_X) begin
                x_next = coord;
            end else begin
                y_next = coord;
                ready  = 1'b1;
            end
        end else if (is_tick) begin
            unique case (phase_reg) inside
                PH_DISCHARGE: begin
                    en_next    = PIN_ALL;
                    lvl_next   = PIN_NONE;
                    count_next = '0;
                end
                PH_SETTLE_X: begin
                    count_next = count_inc;
                    if (settle_hit) begin
                        en_next    = PIN_LEFT | PIN_RIGHT;
                        lvl_next   = PIN_RIGHT;
                        count_next = '0;
                    end
                end
                PH_SETTLE_Y: begin
                    count_next = count_inc;
                    if (settle_hit) begin
                        en_next    = PIN_TOP | PIN_BOTTOM;
                        lvl_next   = PIN_BOTTOM;
                        count_next = '0;
                    end
                end
                PH_READ_X, PH_READ_Y: begin
                    count_next = count_inc;
                    if (settle_hit) begin
                        conv_next = 1'b1;
                        start     = 1'b1;
                    end
                end
                default: count_next = count_reg;
            endcase
        end
    end

    always_comb begin
        res_next.drive_enable = en_next;
        res_next.drive_level  = lvl_next;
        res_next.adc_start    = start;
        res_next.adc_channel  = (phase_next == PH_READ_Y);
        res_next.x_position   = x_next;
        res_next.y_position   = y_next;
        res_next.pair_ready   = ready;
        res_next.phase        = phase_next;
    end

    always_comb begin
        res_valid_next = res_valid_reg;
        if (fire) begin
            res_valid_next = 1'b1;
        end else if (res_ready) begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_DISCHARGE;
            count_reg     <= '0;
            conv_reg      <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            en_reg        <= PIN_ALL;
            lvl_reg       <= PIN_NONE;
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
            if (fire) begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                conv_reg  <= conv_next;
                x_reg     <= x_next;
                y_reg     <= y_next;
                en_reg    <= en_next;
                lvl_reg   <= lvl_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: hdl/resistive_touch_scan_sequencer.sv
// ----------------------------------------------------------------------------
// resistive_touch_scan_sequencer
// Four-wire resistive panel scan: plate drive, settle timing, ADC requests and
// X/Y coordinate capture, one result word per input word.
// ----------------------------------------------------------------------------
//
//   channel   | direction | handshake          | payload
//   ----------+-----------+--------------------+------------------------------
//   s_        | in        | s_tvalid/s_tready  | s_tuser cmd, s_tdata sample
//   m_        | out       | m_tvalid/m_tready  | m_tdata drive/adc/coords/phase
//   cfg_      | in        | cfg_we             | cfg_wdata settle_ticks
//
// One word per clock sustained while neither side stalls; each accepted word
// passes through the input register, then the phase update into the result register.
// The phase machine and settle counter sit between those two registers.
// Reset is synchronous, active low; settle_ticks returns to 5, phase to
// discharge with all plates driven low.
// Either side may stall at any time; a held result does not block acceptance
// while the input register is free.
//
module resistive_touch_scan_sequencer (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rtss_pkg::S_TDATA_W-1:0]    s_tdata,   // [11:0] sample, rest zero
    input  logic                              s_tuser,   // [0] cmd
    // Result words
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [3:0] drive_enable, [7:4] drive_level, [8] adc_start, [9] adc_channel,
    // [17:10] x_position, [25:18] y_position, [26] pair_ready, [29:27] phase,
    // [31:30] zero
    output logic [rtss_pkg::M_TDATA_W-1:0]    m_tdata,
    // Settle time register
    input  logic                              cfg_we,
    input  logic [rtss_pkg::SETTLE_BITS-1:0]  cfg_wdata
);
    import rtss_pkg::*;

    logic [SETTLE_BITS-1:0] settle_reg;
    logic [SETTLE_BITS-1:0] settle_next;

    item_t   s_item;
    item_t   core_item;
    logic    core_valid;
    logic    core_ready;
    result_t core_res;

    // Settle time: write-only register, reset to the default wait.
    assign settle_next = cfg_we ? cfg_wdata : settle_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= SETTLE_RESET;
        end else begin
            settle_reg <= settle_next;
        end
    end

    // Unpack the input word; bits above the sample field drop out here.
    assign s_item.cmd    = cmd_t'(s_tuser);
    assign s_item.sample = s_tdata[SAMPLE_BITS-1:0];

    // Hold the accepted word until the scan core takes it.
    rtss_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (s_item),
        .out_valid (core_valid),
        .out_ready (core_ready),
        .out_item  (core_item)
    );

    // Advance the scan phase and register the result word.
    rtss_scan_core u_scan_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .settle_ticks (settle_reg),
        .in_valid     (core_valid),
        .in_ready     (core_ready),
        .in_item      (core_item),
        .res_valid    (m_tvalid),
        .res_ready    (m_tready),
        .res          (core_res)
    );

    assign m_tdata = pack_result(core_res);

endmodule

// File: hdl/rtss_checker.sv
// ----------------------------------------------------------------------------
// rtss_checker
// Port-level checks on result words of the touch scan sequencer.
// ----------------------------------------------------------------------------
`include "resistive_touch_scan_sequencer_assert.svh"

module rtss_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rtss_pkg::M_TDATA_W-1:0] m_tdata
);
    import rtss_pkg::*;

    logic [MASK_BITS-1:0]  m_en;
    logic [MASK_BITS-1:0]  m_lvl;
    logic                  m_start;
    logic                  m_chan;
    logic                  m_pair;
    logic [PHASE_BITS-1:0] m_phase;

    assign m_en    = m_tdata[OUT_EN_LSB +: MASK_BITS];
    assign m_lvl   = m_tdata[OUT_LVL_LSB +: MASK_BITS];
    assign m_start = m_tdata[OUT_START_BIT];
    assign m_chan  = m_tdata[OUT_CHAN_BIT];
    assign m_pair  = m_tdata[OUT_READY_BIT];
    assign m_phase = m_tdata[OUT_PHASE_LSB +: PHASE_BITS];

    `RTSS_ASSERT_NEXT(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata), "result word changed while stalled")

    `RTSS_ASSERT_NOW(a_start_in_read, aclk, aresetn, m_tvalid && m_start, m_phase == PH_READ_X || m_phase == PH_READ_Y, "conversion request outside a read phase")

    `RTSS_ASSERT_NOW(a_pair_discharged, aclk, aresetn, m_tvalid && m_pair, m_phase == PH_READY && m_en == PIN_ALL && m_lvl == PIN_NONE, "pair ready without discharge")

    `RTSS_ASSERT_NOW(a_channel_phase, aclk, aresetn, m_tvalid, m_chan == (m_phase == PH_READ_Y), "ADC channel disagrees with phase")

    `RTSS_ASSERT_NOW(a_x_drive, aclk, aresetn, m_tvalid && m_phase == PH_READ_X, m_en == (PIN_LEFT | PIN_RIGHT) && m_lvl == PIN_RIGHT, "X plates not driven in read X")

endmodule

bind resistive_touch_scan_sequencer rtss_checker u_rtss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: dv/tb_resistive_touch_scan_sequencer.sv
// ----------------------------------------------------------------------------
// tb_resistive_touch_scan_sequencer
// Self-checking bench for the touch scan sequencer. A short table of words
// walks one full X/Y scan at the reset settle time, then random tick and
// conversion-done traffic runs under several settle times and stall patterns.
// Every result word is checked field by field against its hand-typed row or
// an in-bench prediction of the phase machine.
// ----------------------------------------------------------------------------
module tb_resistive_touch_scan_sequencer;

    import rtss_pkg::*;

    // One row of the directed table: the input word and, where it is obvious,
    // the result word typed in by hand.
    typedef struct packed {
        cmd_t                   cmd;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   typed;
        result_t                want;
    } stim_row_t;

    localparam int TABLE_ROWS = 26;
    localparam int REPORT_MAX = 10;

    // Full scan at the reset settle time of five ticks, starting from reset.
    localparam stim_row_t STIM_TABLE [TABLE_ROWS] = '{
        // conversion done with nothing pending: state unchanged
        '{CMD_DONE, 12'hFFF, 1'b1,
          '{PIN_ALL, PIN_NONE, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0, PH_DISCHARGE}},
        '{CMD_TICK, 12'h000, 1'b1,
          '{PIN_ALL, PIN_NONE, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0, PH_SETTLE_X}},
        '{CMD_TICK, 12'h000, 1'b0, '0},
        '{CMD_TICK, 12'h000, 1'b0, '0},
        '{CMD_TICK, 12'h000, 1'b0, '0},
        '{CMD_TICK, 12'h000, 1'b0, '0},
        // fifth tick: drive the X plates
        '{CMD_TICK, 12'h000, 1'b1,
          '{4'h3, PIN_RIGHT, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0, PH_READ_X}},
        '{CMD_TICK, 12'h000, 1'b0, '0},
        '{CMD_TICK, 12'h000, 1'b0, '0},
        '{CMD_TICK, 12'h000, 1'b0, '0},
        '{CMD_TICK, 12'h000, 1'b0, '0},
        '{CMD_TICK, 12'h000, 1'b1,
          '{4'h3, PIN_RIGHT, 1'b1, 1'b0, 8'h00, 8'h00, 1'b0, PH_READ_X}},
        // tick while converting: ignored
        '{CMD_TICK, 12'h000, 1'b1,
          '{4'h3, PIN_RIGHT, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0, PH_READ_X}},
        '{CMD_DONE, 12'hFFF, 1'b1,
          '{PIN_ALL, PIN_NONE, 1'b0, 1'b0, 8'hFF, 8'h00, 1'b0, PH_SETTLE_Y}},
        '{CMD_TICK, 12'h000, 1'b0, '0},
        '{CMD_TICK, 12'h000, 1'b0, '0},
        '{CMD_TICK, 12'h000, 1'b0, '0},
        '{CMD_TICK, 12'h000, 1'b0, '0},
        '{CMD_TICK, 12'h000, 1'b1,
          '{4'hC, PIN_BOTTOM, 1'b0, 1'b1, 8'hFF, 8'h00, 1'b0, PH_READ_Y}},
        '{CMD_TICK, 12'h000, 1'b0, '0},
        '{CMD_TICK, 12'h000, 1'b0, '0},
        '{CMD_TICK, 12'h000, 1'b0, '0},
        '{CMD_TICK, 12'h000, 1'b0, '0},
        '{CMD_TICK, 12'h000, 1'b1,
          '{4'hC, PIN_BOTTOM, 1'b1, 1'b1, 8'hFF, 8'h00, 1'b0, PH_READ_Y}},
        '{CMD_DONE, 12'h000, 1'b1,
          '{PIN_ALL, PIN_NONE, 1'b0, 1'b0, 8'hFF, 8'h00, 1'b1, PH_READY}},
        // tick in the ready phase restarts the cycle
        '{CMD_TICK, 12'h000, 1'b1,
          '{PIN_ALL, PIN_NONE, 1'b0, 1'b0, 8'hFF, 8'h00, 1'b0, PH_DISCHARGE}}
    };

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [SETTLE_BITS-1:0] cfg_wdata = '0;

    // Stall rates in percent per cycle
    int unsigned send_idle_pct = 23;
    int unsigned recv_idle_pct = 78;

    // Shadow of the sequencer state, at reset values
    logic [SETTLE_BITS-1:0] pred_settle = SETTLE_RESET;
    phase_t                 pred_phase  = PH_DISCHARGE;
    logic [COUNT_BITS-1:0]  pred_count  = '0;
    logic                   pred_busy   = 1'b0;
    logic [COORD_BITS-1:0]  pred_x      = '0;
    logic [COORD_BITS-1:0]  pred_y      = '0;
    logic [MASK_BITS-1:0]   pred_en     = PIN_ALL;
    logic [MASK_BITS-1:0]   pred_lvl    = PIN_NONE;

    result_t     pending_results [$];
    int unsigned words_sent      = 0;
    int unsigned results_checked = 0;
    int unsigned pairs_seen      = 0;
    int unsigned mismatches      = 0;

    resistive_touch_scan_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Advance the shadow state by one word; return the result it produces and
    // whether the word did anything (stray completions and ticks during a
    // conversion leave the state alone).
    function automatic result_t advance_scan(input cmd_t cmd,
                                             input logic [SAMPLE_BITS-1:0] sample,
                                             output bit acted);
        result_t r;
        bit      wait_over;
        r = '0;
        acted = 1'b0;
        wait_over = 1'b0;
        if (cmd == CMD_DONE) begin
            if (pred_busy) begin
                acted = 1'b1;
                pred_busy = 1'b0;
                pred_count = '0;
                pred_en = PIN_ALL;
                pred_lvl = PIN_NONE;
                if (pred_phase == PH_READ_X) begin
                    pred_x = sample[SAMPLE_BITS-1 -: COORD_BITS];
                    pred_phase = PH_SETTLE_Y;
                end else begin
                    pred_y = sample[SAMPLE_BITS-1 -: COORD_BITS];
                    pred_phase = PH_READY;
                    r.pair_ready = 1'b1;
                end
            end
        end else if (!pred_busy) begin
            acted = 1'b1;
            // Count one settle tick; the count saturates and a full count
            // always ends the wait.
            if (pred_phase != PH_DISCHARGE && pred_phase <= PH_READ_Y) begin
                if (pred_count != COUNT_MAX)
                    pred_count = pred_count + 1'b1;
                wait_over = (pred_count >= pred_settle) || (pred_count == COUNT_MAX);
            end
            case (pred_phase)
                PH_DISCHARGE: begin
                    pred_en = PIN_ALL;
                    pred_lvl = PIN_NONE;
                    pred_count = '0;
                    pred_phase = PH_SETTLE_X;
                end
                PH_SETTLE_X: begin
                    if (wait_over) begin
                        pred_en = PIN_LEFT | PIN_RIGHT;
                        pred_lvl = PIN_RIGHT;
                        pred_count = '0;
                        pred_phase = PH_READ_X;
                    end
                end
                PH_SETTLE_Y: begin
                    if (wait_over) begin
                        pred_en = PIN_TOP | PIN_BOTTOM;
                        pred_lvl = PIN_BOTTOM;
                        pred_count = '0;
                        pred_phase = PH_READ_Y;
                    end
                end
                PH_READ_X, PH_READ_Y: begin
                    if (wait_over) begin
                        pred_busy = 1'b1;
                        r.adc_start = 1'b1;
                    end
                end
                default: pred_phase = PH_DISCHARGE;
            endcase
        end
        r.drive_enable = pred_en;
        r.drive_level  = pred_lvl;
        r.adc_channel  = (pred_phase == PH_READ_Y);
        r.x_position   = pred_x;
        r.y_position   = pred_y;
        r.phase        = pred_phase;
        return r;
    endfunction

    // Offer one word, wait for the handshake, then queue its result and
    // insert sender idle cycles at random.
    task automatic push_word(input cmd_t cmd, input logic [SAMPLE_BITS-1:0] sample,
                             input bit given_ok, input result_t given,
                             output bit acted);
        result_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= S_TDATA_W'(sample);
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predicted = advance_scan(cmd, sample, acted);
        pending_results.push_back(given_ok ? given : predicted);
        words_sent++;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // Drain all outstanding results, then write the settle time.
    task automatic set_settle(input logic [SETTLE_BITS-1:0] ticks);
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= ticks;
        @(posedge aclk);
        pred_settle = ticks;
        cfg_we <= 1'b0;
    endtask

    // Random traffic: mostly well-formed scans (ticks, and a completion once a
    // conversion is pending) with some stray completions and ignored ticks.
    // Only words that change state count toward the total.
    task automatic run_scan_words(input int unsigned n_active);
        int unsigned active;
        cmd_t        cmd;
        bit          acted;
        active = 0;
        while (active < n_active) begin
            if (pred_busy)
                cmd = ($urandom_range(0, 99) < 85) ? CMD_DONE : CMD_TICK;
            else
                cmd = ($urandom_range(0, 99) < 8) ? CMD_DONE : CMD_TICK;
            push_word(cmd, SAMPLE_BITS'($urandom()), 1'b0, '0, acted);
            if (acted)
                active++;
        end
        s_tvalid <= 1'b0;
    endtask

    function automatic void compare_field(input string fname, input logic [7:0] want,
                                          input logic [7:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("mismatch on result %0d: %s expected %0h, got %0h",
                         results_checked, fname, want, got);
        end
    endfunction

    // Receiver: randomize ready every cycle, check each accepted result word.
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        if (aresetn && m_tvalid && m_tready) begin
            got.drive_enable = m_tdata[OUT_EN_LSB +: MASK_BITS];
            got.drive_level  = m_tdata[OUT_LVL_LSB +: MASK_BITS];
            got.adc_start    = m_tdata[OUT_START_BIT];
            got.adc_channel  = m_tdata[OUT_CHAN_BIT];
            got.x_position   = m_tdata[OUT_X_LSB +: COORD_BITS];
            got.y_position   = m_tdata[OUT_Y_LSB +: COORD_BITS];
            got.pair_ready   = m_tdata[OUT_READY_BIT];
            got.phase        = phase_t'(m_tdata[OUT_PHASE_LSB +: PHASE_BITS]);
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result word %h with nothing pending", m_tdata);
            end else begin
                want = pending_results.pop_front();
                compare_field("drive_enable", 8'(want.drive_enable), 8'(got.drive_enable));
                compare_field("drive_level", 8'(want.drive_level), 8'(got.drive_level));
                compare_field("adc_start", 8'(want.adc_start), 8'(got.adc_start));
                compare_field("adc_channel", 8'(want.adc_channel), 8'(got.adc_channel));
                compare_field("x_position", want.x_position, got.x_position);
                compare_field("y_position", want.y_position, got.y_position);
                compare_field("pair_ready", 8'(want.pair_ready), 8'(got.pair_ready));
                compare_field("phase", 8'(want.phase), 8'(got.phase));
                if (got.pair_ready)
                    pairs_seen++;
            end
            results_checked++;
        end
    end

    initial begin
        bit acted;
        // Hold reset low, then release it once
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed scan at the reset settle time, sender 23% / receiver 78% idle
        for (int i = 0; i < TABLE_ROWS; i++)
            push_word(STIM_TABLE[i].cmd, STIM_TABLE[i].sample, STIM_TABLE[i].typed,
                      STIM_TABLE[i].want, acted);
        s_tvalid <= 1'b0;

        // Zero settle acts as one tick
        set_settle(16'd0);
        run_scan_words(120);
        set_settle(16'd3);
        run_scan_words(120);

        // Swap the stall rates
        send_idle_pct = 78;
        recv_idle_pct = 23;
        set_settle(16'd1);
        run_scan_words(120);
        // Longest settle, cut short: the next write lands mid-wait
        set_settle(16'hFFFF);
        run_scan_words(40);
        set_settle(16'd2);
        run_scan_words(120);

        // No stalls on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_settle(16'd7);
        run_scan_words(100);
        set_settle(SETTLE_BITS'($urandom_range(4, 12)));
        run_scan_words(100);

        // Drain, then keep watching for stray words
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("run covered %0d words and %0d checked results, %0d X/Y pairs",
                 words_sent, results_checked, pairs_seen);
        $display("settle times 0 to 65535 under three stall patterns, %0d mismatches",
                 mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog: fails the run if it has not finished by the time limit
    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// File: resistive_touch_scan_sequencer.f
+incdir+hdl
hdl/rtss_pkg.sv
hdl/rtss_in_reg.sv
hdl/rtss_scan_core.sv
hdl/resistive_touch_scan_sequencer.sv
hdl/rtss_checker.sv
dv/tb_resistive_touch_scan_sequencer.sv
